[src/lj_pkg.sv]
// Shared types, constants and a helper function for the Lennard-Jones energy engine.
// Used by the channel interfaces and every module under src but lj_ram; depends on nothing.
package lj_pkg;

   localparam int unsigned MAX_ATOMS = 128;
   localparam int unsigned ADDR_W    = $clog2(MAX_ATOMS);
   localparam int unsigned CNT_W     = $clog2(MAX_ATOMS + 1);

   localparam int unsigned COORD_W  = 24;
   localparam int unsigned BOX_W    = 23;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned ENERGY_W = 48;
   localparam int unsigned CSR_IDX_W = 2;

   // datapath widths
   localparam int unsigned DMAG_W  = 26;   // |dx| after minimum image
   localparam int unsigned MUL_W   = 26;   // shared multiplier operand
   localparam int unsigned PROD_W  = 2 * MUL_W;
   localparam int unsigned ACC_W   = 58;   // holds r^2 and u^6
   localparam int unsigned OPER_W  = 41;   // u, u^2, u^3
   localparam int unsigned HALF_W  = 24;   // low half of a Q24 product split
   localparam int unsigned R2_W    = 35;   // r^2 below cutoff
   localparam int unsigned QUO_W   = 29;   // u = 2^56 / r^2
   localparam int unsigned DIV_CNT_W = $clog2(QUO_W);
   localparam int unsigned TERM_W  = 62;
   localparam int unsigned RECIP_SHIFT = 56;

   localparam logic [ACC_W-1:0] CUT2_Q32 = ACC_W'(64'd25 << 30);
   localparam logic [ACC_W-1:0] NEAR_Q32 = ACC_W'(64'd1 << 28);
   localparam logic [R2_W:0]    DIV_SEED = (R2_W + 1)'(64'd1 << (RECIP_SHIFT - QUO_W));

   // pair energy at the cutoff, worked out at elaboration
   localparam longint unsigned UC  = (64'd1 << RECIP_SHIFT) / (64'd25 << 30);
   localparam longint unsigned UC2 = (UC * UC) >> HALF_W;
   localparam longint unsigned UC3 = (UC2 * UC) >> HALF_W;
   localparam longint unsigned UC6 = (UC3 * UC3) >> HALF_W;
   localparam logic signed [TERM_W-1:0] LJ_CUT_Q24 =
      TERM_W'(4 * (longint'(UC6) - longint'(UC3)));

   localparam logic [ENERGY_W-1:0] EMAX = {1'b0, {(ENERGY_W - 1){1'b1}}};
   localparam logic [ENERGY_W-1:0] EMIN = {1'b1, {(ENERGY_W - 1){1'b0}}};
   localparam logic signed [ENERGY_W+1:0] EMAX_X = $signed({3'b000, {(ENERGY_W - 1){1'b1}}});
   localparam logic signed [ENERGY_W+1:0] EMIN_X = $signed({3'b111, {(ENERGY_W - 1){1'b0}}});
   localparam logic signed [TERM_W-1:0] EMAX_T =
      $signed({{(TERM_W - ENERGY_W + 1){1'b0}}, {(ENERGY_W - 1){1'b1}}});

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_MOVE  = 2'd1,
      CMD_TOTAL = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATOM_COUNT = 2'd0,
      CSR_BOX_X      = 2'd1,
      CSR_BOX_Y      = 2'd2,
      CSR_BOX_Z      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PART_HH = 2'd0,
      PART_HL = 2'd1,
      PART_LH = 2'd2,
      PART_LL = 2'd3
   } part_type;

   typedef enum logic [1:0] {
      PH_U2 = 2'd0,
      PH_U3 = 2'd1,
      PH_U6 = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      P_IDLE, P_SQ, P_CHECK, P_DIV, P_MUL, P_FINAL, P_DONE
   } pair_state_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OLD, S_NEXT, S_LOADB, S_PAIR1, S_START2, S_PAIR2, S_FIN,
      S_TA, S_TNEXT, S_TB, S_TPAIR, S_RESP
   } top_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic [BOX_W-1:0] x;
      logic [BOX_W-1:0] y;
      logic [BOX_W-1:0] z;
   } box_type;

   typedef struct packed {
      logic    start;
      vec_type a;
      vec_type b;
   } pair_req_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic                       sat;
      logic signed [ENERGY_W-1:0] term;
   } pair_rsp_type;

   // saturating add; bit ENERGY_W of the result flags a clip
   function automatic logic [ENERGY_W:0] clip_add(input logic [ENERGY_W-1:0] acc,
                                                  input logic [ENERGY_W+1:0] t);
      logic signed [ENERGY_W+1:0] s;
      s = $signed({{2{acc[ENERGY_W-1]}}, acc}) + $signed(t);
      if (s > EMAX_X) begin
         return {1'b1, EMAX};
      end else if (s < EMIN_X) begin
         return {1'b1, EMIN};
      end
      return {1'b0, s[ENERGY_W-1:0]};
   endfunction

endpackage

[src/lj_ifs.sv]
// Valid/ready channel interfaces: request, response and register write port.
// Depends on lj_pkg.
interface lj_req_if;
   import lj_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [6:0]          atom_index;
   logic signed [23:0]  pos_x;
   logic signed [23:0]  pos_y;
   logic signed [23:0]  pos_z;
   modport source (output valid, command, atom_index, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, command, atom_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface lj_rsp_if;
   import lj_pkg::*;
   logic                valid;
   logic                ready;
   logic signed [ENERGY_W-1:0] energy;
   logic                saturated;
   logic                status;
   modport source (output valid, energy, saturated, status, input ready);
   modport sink   (input valid, energy, saturated, status, output ready);
endinterface

interface lj_csr_if;
   import lj_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BOX_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/lj_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lj_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[src/lj_div.sv]
// Restoring divider, one quotient bit a cycle: quotient = 2^56 / divisor.
// Depends on lj_pkg.
module lj_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lj_pkg::R2_W-1:0]   divisor,
   output logic                      done,
   output logic [lj_pkg::QUO_W-1:0]  quotient
);
   import lj_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [R2_W:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [R2_W-1:0]      dvs_ff, dvs_in;
   logic [R2_W:0]        shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff[R2_W-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DIV_SEED;
         quo_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[src/lj_pair.sv]
// Pair energy unit: minimum-image distance, r^2, 1/r^2 and the shifted LJ term,
// all products through one shared 26x26 multiplier. Depends on lj_pkg, lj_div.
module lj_pair (
   input  logic                  clock,
   input  logic                  reset,
   input  lj_pkg::pair_req_type  req,
   input  lj_pkg::box_type       box,
   output lj_pkg::pair_rsp_type  rsp
);
   import lj_pkg::*;

   function automatic logic [DMAG_W-1:0] axis_mag(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b,
                                                  input logic [BOX_W-1:0] bl);
      logic [COORD_W:0]   d;
      logic [COORD_W:0]   dm;
      logic [COORD_W-1:0] am;
      logic [COORD_W-1:0] bm;
      logic [DMAG_W-1:0]  w;
      logic [DMAG_W-1:0]  wm;
      d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      dm = d[COORD_W] ? (~d + 1'b1) : d;
      am = a[COORD_W-1] ? (~a + 1'b1) : a;
      bm = b[COORD_W-1] ? (~b + 1'b1) : b;
      w  = {3'b000, bl} - {2'b00, am} - {2'b00, bm};
      wm = w[DMAG_W-1] ? (~w + 1'b1) : w;
      if ({dm, 1'b0} > {3'b000, bl}) begin
         return wm;
      end
      return {1'b0, dm};
   endfunction

   pair_state_type state_ff, state_in;
   logic [2:0]           cnt_ff, cnt_in;
   part_type             pk_ff, pk_in;
   phase_type            ph_ff, ph_in;
   logic [DMAG_W-1:0]    dmx_ff, dmx_in, dmy_ff, dmy_in, dmz_ff, dmz_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [OPER_W-1:0]    opa_ff, opa_in, opb_ff, opb_in;
   logic [QUO_W-1:0]     u_ff, u_in;
   logic [OPER_W-1:0]    u3_ff, u3_in;
   logic [ENERGY_W-1:0]  term_ff, term_in;
   logic                 tsat_ff, tsat_in;

   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [ACC_W-1:0]     add_term, acc_sum;
   logic signed [TERM_W-1:0] diff, t;
   logic                 div_start, div_done;
   logic [QUO_W-1:0]     quo;

   lj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (acc_ff[R2_W-1:0]),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pk_in    = pk_ff;
      ph_in    = ph_ff;
      dmx_in   = dmx_ff;
      dmy_in   = dmy_ff;
      dmz_in   = dmz_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      u_in     = u_ff;
      u3_in    = u3_ff;
      term_in  = term_ff;
      tsat_in  = tsat_ff;
      div_start = 1'b0;
      mul_a    = '0;
      mul_b    = '0;

      unique case (pk_ff)
         PART_HH: add_term = ACC_W'({prod_ff, {HALF_W{1'b0}}});
         PART_LL: add_term = ACC_W'(prod_ff >> HALF_W);
         default: add_term = ACC_W'(prod_ff);
      endcase
      acc_sum = acc_ff + add_term;

      diff = $signed({{(TERM_W - ACC_W){1'b0}}, acc_ff})
           - $signed({{(TERM_W - OPER_W){1'b0}}, u3_ff});
      t = (diff <<< 2) - LJ_CUT_Q24;

      unique case (state_ff)
         P_IDLE: begin
            if (req.start) begin
               dmx_in   = axis_mag(req.a.x, req.b.x, box.x);
               dmy_in   = axis_mag(req.a.y, req.b.y, box.y);
               dmz_in   = axis_mag(req.a.z, req.b.z, box.z);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = P_SQ;
            end
         end
         P_SQ: begin
            unique case (cnt_ff)
               3'd0:    mul_a = dmx_ff;
               3'd1:    mul_a = dmy_ff;
               3'd2:    mul_a = dmz_ff;
               default: mul_a = '0;
            endcase
            mul_b = mul_a;
            pk_in = PART_HL;
            if (cnt_ff != 3'd0) begin
               acc_in = acc_sum;
            end
            if (cnt_ff == 3'd3) begin
               state_in = P_CHECK;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         P_CHECK: begin
            if (acc_ff >= CUT2_Q32) begin
               term_in  = '0;
               tsat_in  = 1'b0;
               state_in = P_DONE;
            end else if (acc_ff < NEAR_Q32) begin
               term_in  = EMAX;
               tsat_in  = 1'b1;
               state_in = P_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = P_DIV;
            end
         end
         P_DIV: begin
            if (div_done) begin
               u_in     = quo;
               opa_in   = OPER_W'(quo);
               opb_in   = OPER_W'(quo);
               acc_in   = '0;
               cnt_in   = '0;
               ph_in    = PH_U2;
               state_in = P_MUL;
            end
         end
         P_MUL: begin
            // four partials of a 41x41 product; each product is registered before it is accumulated
            unique case (part_type'(cnt_ff[1:0]))
               PART_HH: begin
                  mul_a = MUL_W'(opa_ff[OPER_W-1:HALF_W]);
                  mul_b = MUL_W'(opb_ff[OPER_W-1:HALF_W]);
               end
               PART_HL: begin
                  mul_a = MUL_W'(opa_ff[OPER_W-1:HALF_W]);
                  mul_b = MUL_W'(opb_ff[HALF_W-1:0]);
               end
               PART_LH: begin
                  mul_a = MUL_W'(opa_ff[HALF_W-1:0]);
                  mul_b = MUL_W'(opb_ff[OPER_W-1:HALF_W]);
               end
               PART_LL: begin
                  mul_a = MUL_W'(opa_ff[HALF_W-1:0]);
                  mul_b = MUL_W'(opb_ff[HALF_W-1:0]);
               end
            endcase
            pk_in = part_type'(cnt_ff[1:0]);
            if (cnt_ff != 3'd0) begin
               acc_in = acc_sum;
            end
            if (cnt_ff == 3'd4) begin
               cnt_in = '0;
               acc_in = '0;
               unique case (ph_ff)
                  PH_U2: begin
                     opa_in = acc_sum[OPER_W-1:0];
                     opb_in = OPER_W'(u_ff);
                     ph_in  = PH_U3;
                  end
                  PH_U3: begin
                     u3_in  = acc_sum[OPER_W-1:0];
                     opa_in = acc_sum[OPER_W-1:0];
                     opb_in = acc_sum[OPER_W-1:0];
                     ph_in  = PH_U6;
                  end
                  default: begin
                     acc_in   = acc_sum;
                     state_in = P_FINAL;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         P_FINAL: begin
            if (t > EMAX_T) begin
               term_in = EMAX;
               tsat_in = 1'b1;
            end else begin
               term_in = t[ENERGY_W-1:0];
               tsat_in = 1'b0;
            end
            state_in = P_DONE;
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      pk_ff   <= pk_in;
      ph_ff   <= ph_in;
      dmx_ff  <= dmx_in;
      dmy_ff  <= dmy_in;
      dmz_ff  <= dmz_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      u_ff    <= u_in;
      u3_ff   <= u3_in;
      term_ff <= term_in;
      tsat_ff <= tsat_in;
   end

   assign rsp.busy = (state_ff != P_IDLE);
   assign rsp.done = (state_ff == P_DONE);
   assign rsp.sat  = tsat_ff;
   assign rsp.term = term_ff;
endmodule

[src/lj_energy_change_engine.sv]
// Lennard-Jones energy engine, top level. Depends on lj_pkg, lj_ifs, lj_ram, lj_pair.
// Write, bad index or unused command: the request goes straight to the response state, then to the response word.
// Pair term: squares, cutoff check, divider, multiplier phases and final clip; past cutoff it skips to done.
// Move: two pair terms for every other atom in use; total: one pair term for each pair of atoms in use.
// One word at a time; the shared pair unit and its divider set the rate.
// Reset: registers to atom_count 100, boxes 12.0; position store is not cleared.
module lj_energy_change_engine (
   input  logic     clock,
   input  logic     reset,
   lj_req_if.sink   req_chan,
   lj_rsp_if.source rsp_chan,
   lj_csr_if.sink   csr_chan
);
   import lj_pkg::*;

   // ---------------- configuration registers ----------------
   logic [COUNT_W-1:0] count_ff, count_in;
   box_type            box_ff, box_in;

   // ---------------- sequencer state ----------------
   top_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   i_ff, i_in;        // atom walk / outer loop
   logic [CNT_W-1:0]   j_ff, j_in;        // inner loop of total energy
   logic [6:0]         idx_ff, idx_in;
   vec_type            pos_ff, pos_in;    // new position of a move
   vec_type            old_ff, old_in;    // stored position of the moved atom
   vec_type            a_ff, a_in;
   vec_type            b_ff, b_in;
   logic [ENERGY_W-1:0] enew_ff, enew_in; // also the total-energy sum
   logic [ENERGY_W-1:0] eold_ff, eold_in;
   logic               sat_ff, sat_in;
   logic               status_ff, status_in;

   // ---------------- response register ----------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;
   logic                rsp_sat_ff, rsp_sat_in;
   logic                rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]   n_cur;
   logic               req_acc;
   logic               idx_bad;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [$bits(vec_type)-1:0] ram_rdata;
   vec_type            rd_vec;
   vec_type            req_vec;
   pair_req_type       pair_req;
   pair_rsp_type       pair_rsp;
   logic [ENERGY_W:0]  clip;
   logic [CNT_W-1:0]   i_next;

   lj_ram #(
      .WIDTH ($bits(vec_type)),
      .DEPTH (MAX_ATOMS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (req_vec),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   lj_pair u_pair (
      .clock (clock),
      .reset (reset),
      .req   (pair_req),
      .box   (box_ff),
      .rsp   (pair_rsp)
   );

   assign rd_vec    = vec_type'(ram_rdata);
   assign req_vec.x = req_chan.pos_x;
   assign req_vec.y = req_chan.pos_y;
   assign req_vec.z = req_chan.pos_z;

   // atoms in use: min(atom_count, MAX_ATOMS)
   assign n_cur   = (32'(count_ff) > MAX_ATOMS) ? CNT_W'(MAX_ATOMS) : CNT_W'(count_ff);
   assign idx_bad = (32'(req_chan.atom_index) >= 32'(n_cur));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // ---------------- register writes ----------------
   always_comb begin
      count_in = count_ff;
      box_in   = box_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_ATOM_COUNT: count_in = csr_chan.data[COUNT_W-1:0];
            CSR_BOX_X:      box_in.x = csr_chan.data;
            CSR_BOX_Y:      box_in.y = csr_chan.data;
            CSR_BOX_Z:      box_in.z = csr_chan.data;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      old_in    = old_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      enew_in   = enew_ff;
      eold_in   = eold_ff;
      sat_in    = sat_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_addr  = i_ff[ADDR_W-1:0];
      pair_req.start = 1'b0;
      pair_req.a     = pos_ff;
      pair_req.b     = rd_vec;
      clip      = '0;
      i_next    = i_ff + 1'b1;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_energy_in = rsp_energy_ff;
      rsp_sat_in    = rsp_sat_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               idx_in    = req_chan.atom_index;
               pos_in    = req_vec;
               enew_in   = '0;
               eold_in   = '0;
               sat_in    = 1'b0;
               status_in = 1'b0;
               i_in      = '0;
               unique case (cmd_type'(req_chan.command))
                  CMD_WRITE: begin
                     ram_addr = ADDR_W'(req_chan.atom_index);
                     if (idx_bad) begin
                        status_in = 1'b1;
                     end else begin
                        ram_we = 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  CMD_MOVE: begin
                     ram_addr = ADDR_W'(req_chan.atom_index);
                     if (idx_bad) begin
                        status_in = 1'b1;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_OLD;
                     end
                  end
                  CMD_TOTAL: begin
                     ram_addr = '0;
                     if (32'(n_cur) < 32'd2) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_TA;
                     end
                  end
                  CMD_NONE: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // ---- energy change of a move ----
         S_OLD: begin
            old_in   = rd_vec;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (i_ff == n_cur) begin
               state_in = S_FIN;
            end else if (32'(i_ff) == 32'(idx_ff)) begin
               i_in = i_next;
            end else begin
               state_in = S_LOADB;
            end
         end
         S_LOADB: begin
            b_in           = rd_vec;
            pair_req.start = 1'b1;
            state_in       = S_PAIR1;
         end
         S_PAIR1: begin
            if (pair_rsp.done) begin
               clip     = clip_add(enew_ff, {{2{pair_rsp.term[ENERGY_W-1]}}, pair_rsp.term});
               enew_in  = clip[ENERGY_W-1:0];
               sat_in   = sat_ff | clip[ENERGY_W] | pair_rsp.sat;
               state_in = S_START2;
            end
         end
         S_START2: begin
            pair_req.start = 1'b1;
            pair_req.a     = b_ff;
            pair_req.b     = old_ff;
            state_in       = S_PAIR2;
         end
         S_PAIR2: begin
            if (pair_rsp.done) begin
               clip     = clip_add(eold_ff, {{2{pair_rsp.term[ENERGY_W-1]}}, pair_rsp.term});
               eold_in  = clip[ENERGY_W-1:0];
               sat_in   = sat_ff | clip[ENERGY_W] | pair_rsp.sat;
               i_in     = i_next;
               state_in = S_NEXT;
            end
         end
         S_FIN: begin
            clip     = clip_add(enew_ff, -{{2{eold_ff[ENERGY_W-1]}}, eold_ff});
            enew_in  = clip[ENERGY_W-1:0];
            sat_in   = sat_ff | clip[ENERGY_W];
            state_in = S_RESP;
         end

         // ---- total energy over all pairs ----
         S_TA: begin
            a_in     = rd_vec;
            j_in     = i_next;
            state_in = S_TNEXT;
         end
         S_TNEXT: begin
            if (j_ff == n_cur) begin
               if (32'(i_ff) + 32'd2 >= 32'(n_cur)) begin
                  state_in = S_RESP;
               end else begin
                  i_in     = i_next;
                  ram_addr = i_next[ADDR_W-1:0];
                  state_in = S_TA;
               end
            end else begin
               ram_addr = j_ff[ADDR_W-1:0];
               state_in = S_TB;
            end
         end
         S_TB: begin
            pair_req.start = 1'b1;
            pair_req.a     = a_ff;
            state_in       = S_TPAIR;
         end
         S_TPAIR: begin
            if (pair_rsp.done) begin
               clip     = clip_add(enew_ff, {{2{pair_rsp.term[ENERGY_W-1]}}, pair_rsp.term});
               enew_in  = clip[ENERGY_W-1:0];
               sat_in   = sat_ff | clip[ENERGY_W] | pair_rsp.sat;
               j_in     = j_ff + 1'b1;
               state_in = S_TNEXT;
            end
         end

         // ---- hand the word to the output register once it is free ----
         default: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = enew_ff;
               rsp_sat_in    = sat_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(100);
         box_ff.x     <= BOX_W'(786432);
         box_ff.y     <= BOX_W'(786432);
         box_ff.z     <= BOX_W'(786432);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         box_ff       <= box_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      old_ff        <= old_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      enew_ff       <= enew_in;
      eold_ff       <= eold_in;
      sat_ff        <= sat_in;
      status_ff     <= status_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_sat_ff    <= rsp_sat_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.energy    = rsp_energy_ff;
   assign rsp_chan.saturated = rsp_sat_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // ---------------- assertions ----------------
   // a pair term is only launched into an idle pair unit
   a_pair_idle: assert property (@(posedge clock) disable iff (reset)
      pair_req.start |-> !pair_rsp.busy)
      else $error("pair unit started while busy");

   // a new response word only comes out of the response state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response word without a finished request");

   // the move walk never runs past the atoms in use
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NEXT |-> 32'(i_ff) <= 32'(n_cur))
      else $error("move walk index out of range");

   // the inner loop of the total stays within the atoms in use
   a_inner_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TNEXT |-> (32'(j_ff) <= 32'(n_cur)) && (j_ff > i_ff))
      else $error("total energy inner index out of range");
endmodule
